>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while the given disable term is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> sv/mbt_pkg.sv
`timescale 1ns / 1ps
package mbt_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC    = 26;
  localparam int COUNT_W = 16;

  // full product, combined difference, sum before saturation
  localparam int PW    = 2 * COORD_W;
  localparam int DW    = PW + 1;
  localparam int SW    = PW + 2;
  // |z|^2 accumulator, wide enough to also hold the 4.0 threshold
  localparam int MAG_W = (PW + 1 > 2 * FRAC + 3) ? PW + 1 : 2 * FRAC + 3;
  localparam logic [MAG_W-1:0] THR = {{(MAG_W-1){1'b0}}, 1'b1} << (2 * FRAC + 2);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef struct packed {
    coord_t c_real;
    coord_t c_imag;
    count_t limit;
    logic   zero_limit;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_DONE
  } state_t;

  // clamp to the signed coordinate range
  function automatic coord_t sat_coord(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] maxv;
    logic signed [SW-1:0] minv;
    maxv = {{(SW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    minv = {{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    if (v > maxv) begin
      sat_coord = maxv[COORD_W-1:0];
    end else if (v < minv) begin
      sat_coord = minv[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

>>> sv/mbt_fifo.sv
`timescale 1ns / 1ps
module mbt_fifo
  import mbt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  q_full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  q_empty
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_wr;
  logic           do_rd;

  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/mbt_front.sv
`timescale 1ns / 1ps
module mbt_front
  import mbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  coord_t c_real,
  input  coord_t c_imag,
  input  count_t iteration_limit,
  output logic   q_wr,
  output item_t  q_data,
  input  logic   q_full
);

  logic  front_valid;
  item_t front_item;
  logic  take;
  logic  drain;

  // holding register; drains into the queue whenever there is room
  assign drain  = front_valid && !q_full;
  assign full   = front_valid && q_full;
  assign take   = push && !full;
  assign q_wr   = drain;
  assign q_data = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (drain) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front_item.c_real     <= c_real;
      front_item.c_imag     <= c_imag;
      front_item.limit      <= iteration_limit;
      front_item.zero_limit <= (iteration_limit == '0);
    end
  end

endmodule

>>> sv/mbt_back.sv
`timescale 1ns / 1ps
module mbt_back
  import mbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  item_t  q_data,
  input  logic   q_empty,
  output logic   q_rd,
  output logic   empty,
  input  logic   pop,
  output logic   in_set,
  output count_t iterations_done
);

  state_t state;
  state_t state_next;

  coord_t cx;
  coord_t cy;
  coord_t x;
  coord_t y;
  count_t lim;
  count_t iter;

  logic signed [PW-1:0] sx;
  logic signed [PW-1:0] sy;
  logic signed [PW-1:0] pxy;
  logic [MAG_W-1:0]     mag;
  logic signed [DW-1:0] dx;
  logic signed [PW-1:0] dy;

  logic   res_set;
  count_t res_iter;

  logic   out_valid;
  logic   out_load;

  coord_t nx;
  coord_t ny;
  count_t iter1;
  logic   escape;
  logic   stop;

  // update-step arithmetic
  always_comb begin
    nx     = sat_coord(SW'(dx) + SW'(cx));
    ny     = sat_coord(SW'(dy) + SW'(cy));
    iter1  = iter + 1'b1;
    escape = (mag > THR);
    // unchanged z stays put forever, so jump to the limit
    stop   = ((nx == x) && (ny == y)) || (iter1 == lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_rd       = 1'b1;
          state_next = q_data.zero_limit ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = (escape || stop) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cx       <= q_data.c_real;
        cy       <= q_data.c_imag;
        lim      <= q_data.limit;
        x        <= '0;
        y        <= '0;
        iter     <= '0;
        res_set  <= 1'b1;
        res_iter <= '0;
      end
      ST_MUL: begin
        sx  <= x * x;
        sy  <= y * y;
        pxy <= x * y;
      end
      ST_SUM: begin
        mag <= MAG_W'($unsigned(sx)) + MAG_W'($unsigned(sy));
        dx  <= (DW'(sx) - DW'(sy)) >>> FRAC;
        dy  <= pxy >>> (FRAC - 1);
      end
      ST_UPD: begin
        if (escape) begin
          res_set  <= 1'b0;
          res_iter <= iter;
        end else if (stop) begin
          res_set  <= 1'b1;
          res_iter <= lim;
        end else begin
          x    <= nx;
          y    <= ny;
          iter <= iter1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register, parts the engine from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      in_set          <= res_set;
      iterations_done <= res_iter;
    end
  end

  assign empty = !out_valid;

endmodule

>>> sv/mandelbrot_escape_test.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time test. Each word pushed carries a point c (c_real,
// c_imag, signed Q6.26) and an iteration_limit; the block iterates
// z = z*z + c from z = 0, stops when |z|^2 exceeds 4.0 or the count reaches
// the limit, and returns one word: in_set (count reached the limit) and
// iterations_done. z saturates to the Q6.26 range after each step; a z that
// no longer moves is reported as a member right away. A limit of 0 gives
// in_set = 1, iterations_done = 0. Words come back in push order.
// The iteration loop runs multiply, combine and update steps on one
// shared set of three multipliers; each point is also loaded and
// retired. The passes run are the iterations done when the limit is
// reached, one more when the point escapes (the last pass only tests
// |z|^2), and fewer when z stops moving and the count jumps to the
// limit; a zero limit goes straight from load to retire.
// The engine waits in its retire step while the result register still
// holds an unpopped word. Input side: a holding register and a 4-word
// queue take new points while the engine is busy; output side: a result
// register holds the finished word until popped, while the engine already
// starts on the next point.
module mandelbrot_escape_test
  import mbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  coord_t c_real,
  input  coord_t c_imag,
  input  count_t iteration_limit,
  output logic   empty,
  input  logic   pop,
  output logic   in_set,
  output count_t iterations_done
);

  logic  q_wr;
  item_t q_wdata;
  logic  q_full;
  logic  q_rd;
  item_t q_rdata;
  logic  q_empty;

  // front: accept and tag zero-limit points
  mbt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .iteration_limit (iteration_limit),
    .q_wr            (q_wr),
    .q_data          (q_wdata),
    .q_full          (q_full)
  );

  // decoupling queue between front and engine
  mbt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  // back: iteration engine and result register
  mbt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .in_set          (in_set),
    .iterations_done (iterations_done)
  );

endmodule

>>> sv/mbt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbt_checker
  import mbt_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   full,
  input logic   empty,
  input logic   pop,
  input logic   in_set,
  input count_t iterations_done
);

  // nothing waits on the output right after reset
  `ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, empty)
  // input side is open right after reset
  `ASSERT_NEXT(a_rst_open, clk, 1'b0, rst, !full)
  // a waiting word holds until popped
  `ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(in_set) && $stable(iterations_done))
  // a word that did not reach its limit escaped, so it ran at least one step
  `ASSERT_IMPLIES(a_escape_count, clk, rst, !empty && !in_set, iterations_done != '0)

endmodule

bind mandelbrot_escape_test mbt_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .in_set          (in_set),
  .iterations_done (iterations_done)
);

>>> tb/sv/tb_mandelbrot_escape_test.sv
`timescale 1ns / 1ps
module tb_mandelbrot_escape_test;
  import mbt_pkg::*;

  // 1.0 in Q6.26
  localparam int ONE = 1 << FRAC;

  // Limits of the checker's own arithmetic: every product and sum fits in 96 bits.
  localparam logic signed [95:0] Z_MAX  = (96'sd1 <<< (COORD_W - 1)) - 96'sd1;
  localparam logic signed [95:0] Z_MIN  = -Z_MAX - 96'sd1;
  localparam logic signed [95:0] ESCAPE = 96'sd1 <<< (2 * FRAC + 2);  // 4.0 at 2*FRAC

  // Points whose real work would run past this many steps get a smaller limit.
  localparam int STEP_CAP = 600;

  localparam int N_PROBES = 22;
  localparam int N_RANDOM = 1128;

  typedef struct packed {
    logic   in_set;
    count_t done;
  } escape_t;

  typedef struct {
    coord_t  cr;
    coord_t  ci;
    count_t  lim;
    bit      typed;  // want holds a hand-computed answer
    escape_t want;
  } probe_t;

  logic   clk;
  logic   rst;
  logic   push;
  logic   full;
  coord_t c_real;
  coord_t c_imag;
  count_t iteration_limit;
  logic   empty;
  logic   pop;
  logic   in_set;
  count_t iterations_done;

  escape_t pending_escapes[$];
  probe_t  probes[N_PROBES];
  int      errors;
  int      pop_hold;
  bit      steady;  // no idling on either side for a stretch
  bit      quiet;   // no idling at all in the last part of the run

  mandelbrot_escape_test u_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .iteration_limit (iteration_limit),
    .empty           (empty),
    .pop             (pop),
    .in_set          (in_set),
    .iterations_done (iterations_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed coordinate range.
  function automatic logic signed [95:0] clamp_z(input logic signed [95:0] v);
    if (v > Z_MAX) begin
      return Z_MAX;
    end else if (v < Z_MIN) begin
      return Z_MIN;
    end
    return v;
  endfunction

  // Escape-time count for one point. steps is the number of iterations the
  // engine really has to run: a z that stops moving jumps the count to the
  // limit, so steps can be far below done.
  function automatic void escape_time(input coord_t cr, input coord_t ci, input count_t lim,
                                      output escape_t res, output int steps);
    logic signed [95:0] x, y, sx, sy, nx, ny, cx, cy;
    int n;
    x = '0;
    y = '0;
    cx = cr;
    cy = ci;
    n = 0;
    steps = 0;
    while (n < int'(lim)) begin
      sx = x * x;
      sy = y * y;
      // |z|^2 compared at full precision; exactly 4.0 keeps going
      if (sx + sy > ESCAPE) break;
      // floor scaling via arithmetic shift, then add c and clamp
      nx = clamp_z(((sx - sy) >>> FRAC) + cx);
      ny = clamp_z(((x * y) >>> (FRAC - 1)) + cy);
      n++;
      steps = n;
      if (nx == x && ny == y) begin
        n = int'(lim);
        break;
      end
      x = nx;
      y = ny;
    end
    res.in_set = (n == int'(lim));
    res.done   = n[COUNT_W-1:0];
  endfunction

  // Random point: mostly around the set, some near its edge where orbits
  // run long, some in the +-4 box, some anywhere in the coordinate range.
  function automatic void pick_point(output coord_t cr, output coord_t ci);
    int sel;
    int re;
    int im;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      re = $signed($urandom_range(0, 3 * ONE)) - (9 * ONE / 4);
      im = $signed($urandom_range(0, 5 * ONE / 2)) - (5 * ONE / 4);
    end else if (sel < 80) begin
      case ($urandom_range(0, 5))
        0: begin re = -(3 * ONE / 4); im = ONE / 10; end
        1: begin re = ONE / 4;        im = 0;        end
        2: begin re = -(5 * ONE / 4); im = 0;        end
        3: begin re = -(ONE / 10);    im = 13 * ONE / 20; end
        4: begin re = 3 * ONE / 10;   im = ONE / 2;  end
        default: begin re = -(7 * ONE / 4); im = 0; end
      endcase
      re += $signed($urandom_range(0, 8191)) - 4096;
      im += $signed($urandom_range(0, 8191)) - 4096;
    end else if (sel < 90) begin
      re = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
      im = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
    end else begin
      re = $urandom;
      im = $urandom;
    end
    cr = re;
    ci = im;
  endfunction

  function automatic count_t pick_limit();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return count_t'($urandom_range(0, 3));
    if (sel < 82) return count_t'($urandom_range(4, 40));
    if (sel < 95) return count_t'($urandom_range(41, 300));
    return count_t'($urandom_range(0, 65535));
  endfunction

  // Offer one word; returns at the edge that took it, or after a random idle gap with push low. Called at a clock edge.
  task automatic offer_point(input coord_t cr, input coord_t ci, input count_t lim,
                             input escape_t want);
    c_real          <= cr;
    c_imag          <= ci;
    iteration_limit <= lim;
    push            <= 1'b1;
    do @(posedge clk); while (full);
    pending_escapes.push_back(want);
    if (!quiet && !steady && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Result side: pop with random stall bursts, none in steady or quiet stretches.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (quiet || steady) begin
      pop      <= 1'b1;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(0, 14);
    end else begin
      pop <= 1'b1;
    end
  end

  // Checker: every word taken is matched against the oldest prediction.
  always @(posedge clk) begin : check_word
    escape_t head;
    if (!rst && pop && !empty) begin
      if (pending_escapes.size() == 0) begin
        $display("%0t: unexpected word: in_set=%0b iterations_done=%0d",
                 $time, in_set, iterations_done);
        errors++;
      end else begin
        head = pending_escapes.pop_front();
        if (in_set !== head.in_set) begin
          $display("%0t: in_set mismatch: expected %0b, got %0b",
                   $time, head.in_set, in_set);
          errors++;
        end
        if (iterations_done !== head.done) begin
          $display("%0t: iterations_done mismatch: expected %0d, got %0d",
                   $time, head.done, iterations_done);
          errors++;
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #100_000_000;
    $display("** mandelbrot_escape_test: FAILED **");
    $finish;
  end

  initial begin
    coord_t  cr;
    coord_t  ci;
    count_t  lim;
    escape_t want;
    int      steps;

    rst             = 1'b1;
    push            = 1'b0;
    c_real          = '0;
    c_imag          = '0;
    iteration_limit = '0;
    errors          = 0;
    steady          = 1'b0;
    quiet           = 1'b0;

    // Directed points. Hand-filled answers only where obvious; the rest go
    // through escape_time.
    probes = '{
      // zero limit: member at once, whatever c is
      '{32'h0000_0000, 32'h0000_0000, 16'd0,     1'b1, '{1'b1, 16'd0}},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0,     1'b1, '{1'b1, 16'd0}},
      // c = 0: z never moves, count jumps straight to the full limit
      '{32'h0000_0000, 32'h0000_0000, 16'hFFFF,  1'b1, '{1'b1, 16'hFFFF}},
      // far outside: one step then escape
      '{32'h0800_0000, 32'h0800_0000, 16'd10,    1'b1, '{1'b0, 16'd1}},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,  1'b1, '{1'b0, 16'd1}},
      '{32'h8000_0000, 32'h8000_0000, 16'hFFFF,  1'b1, '{1'b0, 16'd1}},
      // limit of one is reached before the escape test can fire
      '{32'h8000_0000, 32'h7FFF_FFFF, 16'd1,     1'b1, '{1'b1, 16'd1}},
      // c = 2: |z|^2 lands exactly on 4.0, one more step, then escape
      '{32'h0800_0000, 32'h0000_0000, 16'd100,   1'b1, '{1'b0, 16'd2}},
      // c = -2: z settles at 2 and stops moving
      '{32'hF800_0000, 32'h0000_0000, 16'd100,   1'b1, '{1'b1, 16'd100}},
      '{32'h0100_0000, 32'h0000_0000, 16'd1,     1'b1, '{1'b1, 16'd1}},
      // period-2 orbit, preperiodic i, slow creep toward 0.5
      '{32'hFC00_0000, 32'h0000_0000, 16'd50,    1'b0, '{1'b0, 16'd0}},
      '{32'h0000_0000, 32'h0400_0000, 16'd50,    1'b0, '{1'b0, 16'd0}},
      '{32'h0100_0000, 32'h0000_0000, 16'd400,   1'b0, '{1'b0, 16'd0}},
      '{32'hFD00_0000, 32'h0066_6666, 16'd200,   1'b0, '{1'b0, 16'd0}},
      // one-lsb points: floor rounding of negative products
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd20,    1'b0, '{1'b0, 16'd0}},
      '{32'h0000_0001, 32'hFFFF_FFFF, 16'd20,    1'b0, '{1'b0, 16'd0}},
      // c = -2i: |z|^2 exactly 4 on the imaginary axis
      '{32'h0000_0000, 32'hF800_0000, 16'd30,    1'b0, '{1'b0, 16'd0}},
      '{32'h0133_3333, 32'h0200_0000, 16'd255,   1'b0, '{1'b0, 16'd0}},
      '{32'hF900_0000, 32'h0000_0000, 16'd300,   1'b0, '{1'b0, 16'd0}},
      // alternating bit patterns on every field
      '{32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA,  1'b0, '{1'b0, 16'd0}},
      '{32'hAAAA_AAAA, 32'h5555_5555, 16'h5555,  1'b0, '{1'b0, 16'd0}},
      '{32'hFB00_0000, 32'h0000_0000, 16'd1000,  1'b0, '{1'b0, 16'd0}}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      if (probes[i].typed) begin
        want = probes[i].want;
      end else begin
        escape_time(probes[i].cr, probes[i].ci, probes[i].lim, want, steps);
      end
      offer_point(probes[i].cr, probes[i].ci, probes[i].lim, want);
    end

    // Random part, in stretches of 150 words: idling, idling, then steady.
    for (int k = 0; k < N_RANDOM; k++) begin
      steady = ((k / 150) % 3 == 2);
      quiet  = (k >= N_RANDOM - 120);
      pick_point(cr, ci);
      lim = pick_limit();
      escape_time(cr, ci, lim, want, steps);
      // keep long-orbit points affordable; fixed points stay cheap anyway
      if (steps > STEP_CAP) begin
        lim = count_t'($urandom_range(0, STEP_CAP));
        escape_time(cr, ci, lim, want, steps);
      end
      offer_point(cr, ci, lim, want);
    end
    push <= 1'b0;

    while (pending_escapes.size() != 0) @(posedge clk);
    // short tail to catch any stray word
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** mandelbrot_escape_test: PASSED **");
    end else begin
      $display("** mandelbrot_escape_test: FAILED **");
    end
    $finish;
  end

endmodule
